FILE: src/bba_pkg.sv
`default_nettype none

package bba_pkg;

    localparam int INDEX_W        = 13;
    localparam int COUNT_W        = 14;
    localparam int WORD_BITS      = 64;
    localparam int INDEX_SPAN     = 8192;
    localparam int BITMAP_BITS_DEF = 8192;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 14'd7931;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;
        logic clr_step;
        logic cnt_inc;
        logic cnt_dec;
        logic sum_load;
        logic grp_load;
        logic word_pick;
        logic alloc_fin;
        logic rel_fin;
        logic res_busy;
        logic res_full;
        logic res_rel;
        logic out_load;
    } bba_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic over_limit;
        logic is_release;
        logic in_range;
        logic none_free;
        logic out_free;
    } bba_stat_t;

endpackage

`default_nettype wire

FILE: src/bba_ram.sv
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/bba_ctrl.sv
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire bba_stat_t stat,
    output bba_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SUM,
        S_GROUP,
        S_WORD,
        S_ALLOC,
        S_RWRITE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_release)
                begin
                    cmd.cnt_dec = 1'b1;
                    if (stat.in_range)
                    begin
                        // word read is issued here, modified next cycle
                        state_next = S_RWRITE;
                    end
                    else
                    begin
                        cmd.res_rel = 1'b1;
                        state_next  = S_DONE;
                    end
                end
                else if (stat.over_limit)
                begin
                    cmd.res_busy = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_load = 1'b1;
                state_next   = S_GROUP;
            end
            S_GROUP:
            begin
                if (stat.none_free)
                begin
                    cmd.res_full = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.grp_load = 1'b1;
                    state_next   = S_WORD;
                end
            end
            S_WORD:
            begin
                cmd.word_pick = 1'b1;
                state_next    = S_ALLOC;
            end
            S_ALLOC:
            begin
                cmd.alloc_fin = 1'b1;
                state_next    = S_DONE;
            end
            S_RWRITE:
            begin
                cmd.rel_fin = 1'b1;
                cmd.res_rel = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/bba_datapath.sv
`default_nettype none

module bba_datapath
    import bba_pkg::*;
#(
    parameter int BITMAP_BITS = BITMAP_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bba_cmd_t           cmd,
    output bba_stat_t               stat,
    input  wire logic               req_type,
    input  wire logic [INDEX_W-1:0] block_index,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic [1:0]              status,
    output logic [INDEX_W-1:0]      granted_index,
    output logic [COUNT_W-1:0]      free_remaining
);

    localparam int WORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NG    = (WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
    localparam int PADW  = NG * WORD_BITS;
    localparam int SPAN  = (BITMAP_BITS < INDEX_SPAN) ? BITMAP_BITS : INDEX_SPAN;

    // request capture
    logic               req_reg;
    logic [INDEX_W-1:0] blk_reg;

    // control state
    logic [COUNT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic [WAW-1:0]     clr_cnt_reg;
    logic [WORDS-1:0]   full_reg;
    logic               out_valid_reg;

    // search pipeline
    logic [NG-1:0]      grpfree_reg;
    logic [GW-1:0]      grp_reg;
    logic [WAW-1:0]     word_reg;

    // result and output words
    logic [1:0]         res_status_reg;
    logic [INDEX_W-1:0] res_index_reg;
    logic [1:0]         status_reg;
    logic [INDEX_W-1:0] granted_reg;
    logic [COUNT_W-1:0] free_reg;

    logic [PADW-1:0]      full_pad;
    logic [NG-1:0]        grpfree_next;
    logic [GW-1:0]        grp_pick;
    logic [WORD_BITS-1:0] grp_flags;
    logic [5:0]           word_lo;
    logic [WAW-1:0]       word_pick;
    logic [WAW-1:0]       rel_word;
    logic [WORD_BITS-1:0] rdata;
    logic [5:0]           bit_pick;
    logic [WAW+5:0]       pos;
    logic                 alloc_ok;
    logic [WORD_BITS-1:0] alloc_word;
    logic [WORD_BITS-1:0] rel_word_data;
    logic                 ram_we;
    logic [WAW-1:0]       ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WAW-1:0]       ram_raddr;
    logic                 over_limit;
    logic [COUNT_W-1:0]   free_now;

    // summary of full words, padded as full beyond the bitmap
    always_comb
    begin
        full_pad             = '1;
        full_pad[WORDS-1:0]  = full_reg;
    end

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grpfree_next[g] = ~&full_pad[g*WORD_BITS +: WORD_BITS];
        end
    end

    always_comb
    begin
        grp_pick = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grpfree_reg[g])
            begin
                grp_pick = GW'(g);
            end
        end
    end

    assign grp_flags = full_pad[{grp_reg, 6'd0} +: WORD_BITS];

    always_comb
    begin
        word_lo = '0;
        for (int w = WORD_BITS - 1; w >= 0; w--)
        begin
            if (!grp_flags[w])
            begin
                word_lo = 6'(w);
            end
        end
    end

    assign word_pick = WAW'({grp_reg, word_lo});
    assign rel_word  = WAW'(blk_reg >> 6);

    // lowest clear bit of the word read back
    always_comb
    begin
        bit_pick = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!rdata[b])
            begin
                bit_pick = 6'(b);
            end
        end
    end

    assign pos           = {word_reg, bit_pick};
    assign alloc_ok      = (~&rdata) && (32'(pos) < 32'(SPAN));
    assign alloc_word    = rdata | (64'(1) << bit_pick);
    assign rel_word_data = rdata & ~(64'(1) << blk_reg[5:0]);

    assign ram_we    = cmd.clr_step || (cmd.alloc_fin && alloc_ok) || cmd.rel_fin;
    assign ram_raddr = cmd.word_pick ? word_pick : rel_word;

    always_comb
    begin
        if (cmd.clr_step)
        begin
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (cmd.alloc_fin)
        begin
            ram_waddr = word_reg;
            ram_wdata = alloc_word;
        end
        else
        begin
            ram_waddr = rel_word;
            ram_wdata = rel_word_data;
        end
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign over_limit = (cnt_reg >= limit_reg);
    assign free_now   = over_limit ? '0 : (limit_reg - cnt_reg);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.cnt_dec && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            cnt_reg       <= '0;
            clr_cnt_reg   <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.alloc_fin && alloc_ok)
            begin
                full_reg[word_reg] <= &alloc_word;
            end
            else if (cmd.rel_fin)
            begin
                full_reg[rel_word] <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg <= req_type;
            blk_reg <= block_index;
        end
        if (cmd.sum_load)
        begin
            grpfree_reg <= grpfree_next;
        end
        if (cmd.grp_load)
        begin
            grp_reg <= grp_pick;
        end
        if (cmd.word_pick)
        begin
            word_reg <= word_pick;
        end
        if (cmd.alloc_fin)
        begin
            res_status_reg <= alloc_ok ? STATUS_OK : STATUS_FULL;
            res_index_reg  <= alloc_ok ? INDEX_W'(pos) : '0;
        end
        else if (cmd.res_busy)
        begin
            res_status_reg <= STATUS_NO_FREE;
            res_index_reg  <= '0;
        end
        else if (cmd.res_full)
        begin
            res_status_reg <= STATUS_FULL;
            res_index_reg  <= '0;
        end
        else if (cmd.res_rel)
        begin
            res_status_reg <= STATUS_OK;
            res_index_reg  <= '0;
        end
        if (cmd.out_load)
        begin
            status_reg  <= res_status_reg;
            granted_reg <= res_index_reg;
            free_reg    <= free_now;
        end
    end

    assign stat.clr_last   = (clr_cnt_reg == WAW'(WORDS - 1));
    assign stat.over_limit = over_limit;
    assign stat.is_release = (req_reg == REQ_RELEASE);
    assign stat.in_range   = (32'(blk_reg) < 32'(BITMAP_BITS));
    assign stat.none_free  = ~|grpfree_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_index  = granted_reg;
    assign free_remaining = free_reg;

endmodule

`default_nettype wire

FILE: src/block_bitmap_allocator.sv
// Free-block allocator: one bitmap bit per block plus a count of blocks out.
// Input channel (in_valid / in_stall): req_type 0 allocates the lowest free
// block, 1 releases block_index. Output channel (out_valid / out_stall)
// carries one word per request: status, granted_index, free_remaining.
// The limit register is written through cfg_wr_en / cfg_wr_data.
// One request is worked on at a time; in_stall is low only when idle.
// An allocate that searches runs decode, summary load, group pick, word
// pick and bit pick with write back; with no free word it stops after the
// group pick. A release inside the bitmap reads and writes back its word;
// one beyond it or an allocate refused by count goes from decode to the
// result. A new request is taken the cycle after the result is loaded. The
// search cost comes from the full-word summary scan, the 64-bit word pick
// and the bitmap memory's registered read followed by a write back. After
// reset a clearing pass zeroes the bitmap memory, one 64-bit word a cycle
// (BITMAP_BITS / 64 words, 128 by default); in_stall stays high during it.
// If the receiver stalls, the result word holds in the output register; a
// following request is still taken and waits to be loaded.
`default_nettype none

module block_bitmap_allocator
    import bba_pkg::*;
#(
    parameter int BITMAP_BITS = BITMAP_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               req_type,
    input  wire logic [INDEX_W-1:0] block_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [INDEX_W-1:0]      granted_index,
    output logic [COUNT_W-1:0]      free_remaining,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data
);

    bba_cmd_t  cmd;
    bba_stat_t stat;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_datapath #(
        .BITMAP_BITS (BITMAP_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .block_index    (block_index),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .granted_index  (granted_index),
        .free_remaining (free_remaining)
    );

endmodule

`default_nettype wire
